// ----- src/serial_load_bank_mapper_core_macros.svh -----
// Assertion macros shared by the serial-load bank mapper RTL.
// Defining ASSERT_OFF turns every assertion into empty text.
`ifndef SERIAL_LOAD_BANK_MAPPER_CORE_MACROS_SVH
`define SERIAL_LOAD_BANK_MAPPER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SLBM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slbm assertion failed");
`define SLBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slbm assertion failed");
`else
`define SLBM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SLBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/slbm_pkg.sv -----
// Package for the serial-load bank mapper: target codes, register select codes,
// mirroring codes, the bank-count register address and reset constants. No dependencies.
package slbm_pkg;

	typedef enum logic [2:0] {
		TGT_NONE      = 3'd0,
		TGT_PRG_ROM   = 3'd1,
		TGT_PRG_RAM   = 3'd2,
		TGT_PATTERN   = 3'd3,
		TGT_NAMETABLE = 3'd4
	} target_t;

	typedef enum logic [1:0] {
		SEL_CONTROL      = 2'd0,
		SEL_PATTERN_LOW  = 2'd1,
		SEL_PATTERN_HIGH = 2'd2,
		SEL_PROGRAM      = 2'd3
	} commit_sel_t;

	typedef enum logic [1:0] {
		MIR_ONE_LOW  = 2'd0,
		MIR_ONE_HIGH = 2'd1,
		MIR_VERTICAL = 2'd2,
		MIR_HORIZ    = 2'd3
	} mirror_t;

	localparam logic [1:0] ADDR_PRG_BANK_COUNT = 2'd0;
	localparam logic [4:0] SHIFT_MARK          = 5'h10;
	localparam logic [4:0] CTRL_RESET          = 5'h0C;
	localparam logic [4:0] PRG_COUNT_RESET     = 5'd16;

endpackage

// ----- src/serial_load_bank_mapper_core.sv -----
// Serial-load bank mapper core: translates bus accesses and keeps the bank registers.
// Depends on slbm_pkg and serial_load_bank_mapper_core_macros.svh.

// The block takes one bus access per clock while in_stall is low and returns one
// transaction of target, translated address, write enable and data for each. An
// access is held in the input register, where the bank registers are read and
// updated, and then in the result register, which drives the output; the result
// register holds while the output is stalled. The rate is one access per cycle
// when the output is not stalled, set by the single translation stage between
// those two registers.
`include "serial_load_bank_mapper_core_macros.svh"

module serial_load_bank_mapper_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [15:0]          address,
	input  logic [7:0]           write_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output slbm_pkg::target_t    target,
	output logic [17:0]          mem_address,
	output logic                 write_enable,
	output logic [7:0]           data_out,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [1:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import slbm_pkg::*;

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [15:0] address_s1;
	logic [7:0]  write_data_s1;
	logic        valid_s2;
	target_t     target_s2;
	logic [17:0] mem_address_s2;
	logic        write_enable_s2;
	logic [7:0]  data_out_s2;

	logic [4:0] prg_count_q;
	logic [4:0] shift_q;
	logic [4:0] control_q;
	logic [4:0] pat_low_q;
	logic [4:0] pat_high_q;
	logic [4:0] program_q;

	logic        advance;
	logic        process;
	logic        cfg_write;
	logic        cpu_side;
	logic        is_write;
	logic        serial_wr;
	logic        reset_wr;
	logic        commit;
	logic [4:0]  shift_next;
	logic [3:0]  bank;
	logic [3:0]  last_bank;
	logic [3:0]  prg_sel;
	logic [17:0] prg_addr;
	logic [17:0] pat_addr;
	logic        nt_hi;
	target_t     tgt_c;
	logic [17:0] maddr_c;
	logic        we_c;

	assign advance   = !valid_s2 || !out_stall;
	assign process   = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr == ADDR_PRG_BANK_COUNT) ? {27'd0, prg_count_q} : 32'd0;

	assign cpu_side   = !mode_s1[1];
	assign is_write   = mode_s1[0];
	assign serial_wr  = cpu_side && is_write && address_s1[15];
	assign reset_wr   = serial_wr && write_data_s1[7];
	assign commit     = serial_wr && !write_data_s1[7] && shift_q[0];
	assign shift_next = {write_data_s1[0], shift_q[4:1]};

	assign bank      = program_q[3:0];
	assign last_bank = 4'(prg_count_q - 5'd1);

	always_comb begin
		unique case (control_q[3:2])
			2'd0, 2'd1: prg_sel = bank;
			2'd2: prg_sel = address_s1[14] ? bank : 4'd0;
			default: prg_sel = address_s1[14] ? last_bank : bank;
		endcase
		if (!control_q[3]) begin
			prg_addr = {bank[3:1], address_s1[14:0]};
		end else begin
			prg_addr = {prg_sel, address_s1[13:0]};
		end

		if (!control_q[4]) begin
			pat_addr = {1'b0, pat_low_q[4:1], address_s1[12:0]};
		end else if (address_s1[12]) begin
			pat_addr = {1'b0, pat_high_q, address_s1[11:0]};
		end else begin
			pat_addr = {1'b0, pat_low_q, address_s1[11:0]};
		end

		unique case (mirror_t'(control_q[1:0]))
			MIR_ONE_LOW:  nt_hi = 1'b0;
			MIR_ONE_HIGH: nt_hi = 1'b1;
			MIR_VERTICAL: nt_hi = address_s1[10];
			MIR_HORIZ:    nt_hi = address_s1[11];
			default:      nt_hi = 1'b0;
		endcase

		tgt_c   = TGT_NONE;
		maddr_c = 18'd0;
		if (cpu_side) begin
			if (address_s1[15]) begin
				if (!is_write) begin
					tgt_c   = TGT_PRG_ROM;
					maddr_c = prg_addr;
				end
			end else if (address_s1[14:13] == 2'b11) begin
				tgt_c   = TGT_PRG_RAM;
				maddr_c = {5'd0, address_s1[12:0]};
			end
		end else if (!address_s1[13]) begin
			tgt_c   = TGT_PATTERN;
			maddr_c = pat_addr;
		end else if (address_s1[13:8] != 6'h3F) begin
			tgt_c   = TGT_NAMETABLE;
			maddr_c = {7'd0, nt_hi, address_s1[9:0]};
		end
		we_c = is_write && (tgt_c != TGT_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			mode_s1       <= mode;
			address_s1    <= address;
			write_data_s1 <= write_data;
		end
		if (process) begin
			target_s2       <= tgt_c;
			mem_address_s2  <= maddr_c;
			write_enable_s2 <= we_c;
			data_out_s2     <= we_c ? write_data_s1 : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= PRG_COUNT_RESET;
			shift_q     <= SHIFT_MARK;
			control_q   <= CTRL_RESET;
			pat_low_q   <= 5'd0;
			pat_high_q  <= 5'd0;
			program_q   <= 5'd0;
		end else begin
			if (cfg_write && paddr == ADDR_PRG_BANK_COUNT) begin
				prg_count_q <= pwdata[4:0];
			end
			if (process && serial_wr) begin
				if (reset_wr) begin
					shift_q   <= SHIFT_MARK;
					control_q <= control_q | CTRL_RESET;
				end else if (commit) begin
					shift_q <= SHIFT_MARK;
					unique case (commit_sel_t'(address_s1[14:13]))
						SEL_CONTROL:      control_q  <= shift_next;
						SEL_PATTERN_LOW:  pat_low_q  <= shift_next;
						SEL_PATTERN_HIGH: pat_high_q <= shift_next;
						SEL_PROGRAM:      program_q  <= shift_next;
						default:          program_q  <= shift_next;
					endcase
				end else begin
					shift_q <= shift_next;
				end
			end
		end
	end

	assign out_valid    = valid_s2;
	assign target       = target_s2;
	assign mem_address  = mem_address_s2;
	assign write_enable = write_enable_s2;
	assign data_out     = data_out_s2;

	`SLBM_ASSERT_IMPLY(a_we_has_target, clk, arst_n, valid_s2 && write_enable_s2,
		target_s2 != TGT_NONE)
	`SLBM_ASSERT_IMPLY(a_data_zero_on_read, clk, arst_n, valid_s2 && !write_enable_s2,
		data_out_s2 == 8'd0)
	`SLBM_ASSERT_IMPLY(a_marker_present, clk, arst_n, 1'b1, shift_q != 5'd0)
	`SLBM_ASSERT_NEXT(a_result_follows, clk, arst_n, process, valid_s2)
	`SLBM_ASSERT_NEXT(a_reset_write_mode, clk, arst_n, process && reset_wr,
		control_q[3:2] == 2'b11 && shift_q == SHIFT_MARK)

endmodule
